/* rtl/asl_pkg.sv */
package asl_pkg;

    // Field widths
    localparam int unsigned CMD_W  = 16;
    localparam int unsigned DT_W   = 16;
    localparam int unsigned RATE_W = 24;
    localparam int unsigned LIM_W  = 15;
    localparam int unsigned THR_W  = 15;
    localparam int unsigned STEP_W = 16;
    localparam int unsigned PROD_W = RATE_W + DT_W;
    // Bounds after adding a step to a 16-bit value, with sign
    localparam int unsigned WIDE_W = CMD_W + 2;

    localparam logic [DT_W-1:0]   MIN_TIME_STEP = DT_W'(7);
    localparam logic [THR_W-1:0]  THROTTLE_FULL = THR_W'(16384);
    localparam logic [RATE_W-1:0] RATE_RESET    = RATE_W'(16384);
    localparam logic [LIM_W-1:0]  LIMIT_RESET   = LIM_W'(8192);

    typedef logic signed [CMD_W-1:0]  cmd_t;
    typedef logic signed [WIDE_W-1:0] wide_t;
    typedef logic [STEP_W-1:0]        step_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_RATE  = 2'd0,
        REG_LIMIT = 2'd1
    } reg_idx_t;

endpackage

/* rtl/asl_step_unit.sv */
module asl_step_unit (
    input  logic [asl_pkg::RATE_W-1:0] rate,
    input  logic [asl_pkg::DT_W-1:0]   time_step,
    output asl_pkg::step_t             step
);

    logic [asl_pkg::DT_W-1:0]          dt;
    logic [asl_pkg::PROD_W-1:0]        prod;
    logic [asl_pkg::RATE_W-1:0]        shifted;

    // Floor the time step, scale by the rate, drop the 2^-16 fraction, saturate to 16 bits
    always_comb
    begin
        dt      = (time_step < asl_pkg::MIN_TIME_STEP) ? asl_pkg::MIN_TIME_STEP : time_step;
        prod    = asl_pkg::PROD_W'(rate) * asl_pkg::PROD_W'(dt);
        shifted = prod[asl_pkg::PROD_W-1:asl_pkg::DT_W];
        if (|shifted[asl_pkg::RATE_W-1:asl_pkg::STEP_W])
            step = '1;
        else
            step = shifted[asl_pkg::STEP_W-1:0];
    end

endmodule

/* rtl/asl_surface_clamp.sv */
module asl_surface_clamp (
    input  asl_pkg::cmd_t             cmd,
    input  asl_pkg::cmd_t             last,
    input  asl_pkg::step_t            step,
    input  logic [asl_pkg::LIM_W-1:0] limit,
    output asl_pkg::cmd_t             result
);

    asl_pkg::wide_t cmd_w;
    asl_pkg::wide_t last_w;
    asl_pkg::wide_t step_w;
    asl_pkg::wide_t lo;
    asl_pkg::wide_t hi;
    asl_pkg::wide_t lim_p;
    asl_pkg::wide_t lim_n;
    asl_pkg::wide_t slewed;
    asl_pkg::wide_t bounded;

    always_comb
    begin
        cmd_w  = {{2{cmd[asl_pkg::CMD_W-1]}}, cmd};
        last_w = {{2{last[asl_pkg::CMD_W-1]}}, last};
        step_w = {2'b00, step};
        lo     = last_w - step_w;
        hi     = last_w + step_w;
        lim_p  = {3'b000, limit};
        lim_n  = -lim_p;

        // Slew window around the previous output first
        slewed = (cmd_w > hi) ? hi : cmd_w;
        if (slewed < lo)
            slewed = lo;

        // Then the absolute surface range
        bounded = (slewed > lim_p) ? lim_p : slewed;
        if (bounded < lim_n)
            bounded = lim_n;

        result = bounded[asl_pkg::CMD_W-1:0];
    end

endmodule

/* rtl/actuator_slew_and_limit.sv */
// Channel | Direction | Handshake                | Payload
// --------+-----------+--------------------------+------------------------------------------
// in      | sink      | in_valid / in_stall      | roll/pitch/yaw/throttle_command, time_step
// out     | source    | out_valid / out_stall    | roll_out, pitch_out, yaw_out, throttle_out
// cfg     | sink      | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// One word per clock in and out while out_stall is low; out_valid is stage three's valid.
// Stage one is the input register, stage two holds the registered step from the
// 24x16 rate multiplier, stage three is the result register fed by the clamps.
// Reset clears the valid flags and the previous surface outputs, and loads the two
// config registers with their defaults.
// Stages close up over bubbles; in_stall rises only when all three stages hold a word
// and out_stall is high. cfg_ready is always high.
module actuator_slew_and_limit (
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        in_valid,
    output logic                        in_stall,
    input  asl_pkg::cmd_t               roll_command,
    input  asl_pkg::cmd_t               pitch_command,
    input  asl_pkg::cmd_t               yaw_command,
    input  logic signed [15:0]          throttle_command,
    input  logic [asl_pkg::DT_W-1:0]    time_step,

    output logic                        out_valid,
    input  logic                        out_stall,
    output asl_pkg::cmd_t               roll_out,
    output asl_pkg::cmd_t               pitch_out,
    output asl_pkg::cmd_t               yaw_out,
    output logic [asl_pkg::THR_W-1:0]   throttle_out,

    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [1:0]                  cfg_index,
    input  logic [asl_pkg::RATE_W-1:0]  cfg_data
);

    // Configuration
    logic [asl_pkg::RATE_W-1:0] rate_reg;
    logic [asl_pkg::LIM_W-1:0]  limit_reg;

    // Stage one: input register
    logic                       s1_valid_reg;
    asl_pkg::cmd_t              s1_roll_reg;
    asl_pkg::cmd_t              s1_pitch_reg;
    asl_pkg::cmd_t              s1_yaw_reg;
    logic signed [15:0]         s1_thr_reg;
    logic [asl_pkg::DT_W-1:0]   s1_dt_reg;

    // Stage two: step and clamped throttle
    logic                       s2_valid_reg;
    asl_pkg::cmd_t              s2_roll_reg;
    asl_pkg::cmd_t              s2_pitch_reg;
    asl_pkg::cmd_t              s2_yaw_reg;
    logic [asl_pkg::THR_W-1:0]  s2_thr_reg;
    asl_pkg::step_t             s2_step_reg;

    // Stage three: result register
    logic                       s3_valid_reg;
    asl_pkg::cmd_t              s3_roll_reg;
    asl_pkg::cmd_t              s3_pitch_reg;
    asl_pkg::cmd_t              s3_yaw_reg;
    logic [asl_pkg::THR_W-1:0]  s3_thr_reg;

    // Previous surface outputs
    asl_pkg::cmd_t              last_roll_reg;
    asl_pkg::cmd_t              last_pitch_reg;
    asl_pkg::cmd_t              last_yaw_reg;
    asl_pkg::cmd_t              last_roll_next;
    asl_pkg::cmd_t              last_pitch_next;
    asl_pkg::cmd_t              last_yaw_next;

    logic                       adv1;
    logic                       adv2;
    logic                       adv3;
    asl_pkg::step_t             step;
    logic [asl_pkg::THR_W-1:0]  thr_sat;

    // A stage takes a word when it is empty or its word moves on
    assign adv3     = !s3_valid_reg || !out_stall;
    assign adv2     = !s2_valid_reg || adv3;
    assign adv1     = !s1_valid_reg || adv2;
    assign in_stall = !adv1;
    assign cfg_ready = 1'b1;

    assign out_valid    = s3_valid_reg;
    assign roll_out     = s3_roll_reg;
    assign pitch_out    = s3_pitch_reg;
    assign yaw_out      = s3_yaw_reg;
    assign throttle_out = s3_thr_reg;

    // Register writes; unknown indexes drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg  <= asl_pkg::RATE_RESET;
            limit_reg <= asl_pkg::LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                asl_pkg::REG_RATE:  rate_reg  <= cfg_data;
                asl_pkg::REG_LIMIT: limit_reg <= cfg_data[asl_pkg::LIM_W-1:0];
                default:            ;
            endcase
        end
    end

    asl_step_unit u_step (
        .rate      (rate_reg),
        .time_step (s1_dt_reg),
        .step      (step)
    );

    // Throttle to zero through full scale
    always_comb
    begin
        if (s1_thr_reg[15])
            thr_sat = '0;
        else if (s1_thr_reg[14:0] > asl_pkg::THROTTLE_FULL)
            thr_sat = asl_pkg::THROTTLE_FULL;
        else
            thr_sat = s1_thr_reg[14:0];
    end

    asl_surface_clamp u_roll (
        .cmd    (s2_roll_reg),
        .last   (last_roll_reg),
        .step   (s2_step_reg),
        .limit  (limit_reg),
        .result (last_roll_next)
    );

    asl_surface_clamp u_pitch (
        .cmd    (s2_pitch_reg),
        .last   (last_pitch_reg),
        .step   (s2_step_reg),
        .limit  (limit_reg),
        .result (last_pitch_next)
    );

    asl_surface_clamp u_yaw (
        .cmd    (s2_yaw_reg),
        .last   (last_yaw_reg),
        .step   (s2_step_reg),
        .limit  (limit_reg),
        .result (last_yaw_next)
    );

    // Valid flags and previous outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            last_roll_reg  <= '0;
            last_pitch_reg <= '0;
            last_yaw_reg   <= '0;
        end
        else
        begin
            if (adv1)
                s1_valid_reg <= in_valid;
            if (adv2)
                s2_valid_reg <= s1_valid_reg;
            if (adv3)
                s3_valid_reg <= s2_valid_reg;
            // Advance the surface history only when a word enters the result register
            if (adv3 && s2_valid_reg)
            begin
                last_roll_reg  <= last_roll_next;
                last_pitch_reg <= last_pitch_next;
                last_yaw_reg   <= last_yaw_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid)
        begin
            s1_roll_reg  <= roll_command;
            s1_pitch_reg <= pitch_command;
            s1_yaw_reg   <= yaw_command;
            s1_thr_reg   <= throttle_command;
            s1_dt_reg    <= time_step;
        end
        if (adv2 && s1_valid_reg)
        begin
            s2_roll_reg  <= s1_roll_reg;
            s2_pitch_reg <= s1_pitch_reg;
            s2_yaw_reg   <= s1_yaw_reg;
            s2_thr_reg   <= thr_sat;
            s2_step_reg  <= step;
        end
        if (adv3 && s2_valid_reg)
        begin
            s3_roll_reg  <= last_roll_next;
            s3_pitch_reg <= last_pitch_next;
            s3_yaw_reg   <= last_yaw_next;
            s3_thr_reg   <= s2_thr_reg;
        end
    end

    // The history always matches the word in the result register
    a_last_matches_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_roll_reg == roll_out && last_pitch_reg == pitch_out
                       && last_yaw_reg == yaw_out))
        else $error("surface history differs from the result register");

    // Input backs up only with every stage full and the output stalled
    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && s2_valid_reg && s3_valid_reg && out_stall))
        else $error("input stalled with room in the pipeline");

    a_throttle_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (throttle_out <= asl_pkg::THROTTLE_FULL))
        else $error("throttle above full scale");

endmodule
